// ----- src/sfws_pkg.sv -----
// Shared types and constants of the sample FIFO with window statistics.
// Used by the channel interfaces and by every module of the block but the divider.
// Depends on nothing.
package sfws_pkg;

  localparam int MAX_DEPTH_DEF   = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  // Widths fixed by the register and result fields.
  localparam int DEPTH_W     = 7;
  localparam int CNT_W       = 7;
  localparam int DEPTH_RESET = 64;

  typedef logic [1:0] action_t;
  typedef logic [1:0] status_t;

  localparam action_t ACT_ENQ  = 2'd0;
  localparam action_t ACT_DEQ  = 2'd1;
  localparam action_t ACT_STAT = 2'd2;

  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    latch;
    logic    enq_write;
    logic    deq_read;
    logic    stat_init;
    logic    walk;
    logic    div_start;
    logic    status_we;
    status_t status_code;
    logic    load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    action_t act;
    logic    empty;
    logic    full;
    logic    walk_done;
    logic    div_busy;
    logic    out_free;
  } stat_t;

endpackage

// ----- src/sfws_if.sv -----
// Valid/ready channel interfaces for the input and result words.
// Depends on sfws_pkg for action, status and width defaults.
interface sfws_in_if #(
  parameter int SAMPLE_BITS = sfws_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  sfws_pkg::action_t             action;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, action, sample, input ready);
  modport sink (input valid, action, sample, output ready);
endinterface

interface sfws_out_if #(
  parameter int SAMPLE_BITS = sfws_pkg::SAMPLE_BITS_DEF
);
  logic                           valid;
  logic                           ready;
  sfws_pkg::status_t              status;
  logic signed [SAMPLE_BITS-1:0]  data_out;
  logic [sfws_pkg::CNT_W-1:0]     count;
  logic signed [SAMPLE_BITS-1:0]  minimum;
  logic signed [SAMPLE_BITS-1:0]  maximum;
  logic signed [SAMPLE_BITS-1:0]  mean;
  logic                           rising;
  logic                           single;

  modport source (output valid, status, data_out, count, minimum, maximum, mean,
                  rising, single, input ready);
  modport sink (input valid, status, data_out, count, minimum, maximum, mean,
                rising, single, output ready);
endinterface

// ----- src/sfws_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Self-contained; used by sfws_dp for the mean.
module sfws_div #(
  parameter int N_W = 23,
  parameter int D_W = 7
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           busy,
  output logic [N_W-1:0] quotient
);

  localparam int C_W = $clog2(N_W + 1);

  logic [C_W-1:0] steps;
  logic [N_W-1:0] q;
  logic [D_W-1:0] r;
  logic [D_W-1:0] dv;
  logic [D_W:0]   trial;
  logic [D_W:0]   diff;
  logic           ge;

  assign trial    = {r, q[N_W-1]};
  assign diff     = trial - {1'b0, dv};
  assign ge       = (trial >= {1'b0, dv});
  assign busy     = (steps != '0);
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps <= C_W'(N_W);
    end else if (busy) begin
      steps <= steps - C_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q  <= dividend;
      r  <= '0;
      dv <= divisor;
    end else if (busy) begin
      q <= {q[N_W-2:0], ge};
      // A failed trial is below the divisor, so it fits in D_W bits.
      r <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
    end
  end

endmodule

// ----- src/sfws_dp.sv -----
// Datapath: sample memory, queue pointers, statistics walk, divider and the
// result register. Depends on sfws_pkg and instantiates sfws_div.
module sfws_dp #(
  parameter int MAX_DEPTH   = sfws_pkg::MAX_DEPTH_DEF,
  parameter int SAMPLE_BITS = sfws_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [sfws_pkg::DEPTH_W-1:0]   cfg_wr_data,
  input  sfws_pkg::action_t              in_action,
  input  logic signed [SAMPLE_BITS-1:0]  in_sample,
  input  sfws_pkg::cmd_t                 cmd,
  output sfws_pkg::stat_t                st,
  input  logic                           out_ready,
  output logic                           out_valid,
  output sfws_pkg::status_t              out_status,
  output logic signed [SAMPLE_BITS-1:0]  out_data,
  output logic [sfws_pkg::CNT_W-1:0]     out_count,
  output logic signed [SAMPLE_BITS-1:0]  out_min,
  output logic signed [SAMPLE_BITS-1:0]  out_max,
  output logic signed [SAMPLE_BITS-1:0]  out_mean,
  output logic                           out_rising,
  output logic                           out_single
);

  localparam int DEPTH_W = sfws_pkg::DEPTH_W;
  localparam int CNT_W   = sfws_pkg::CNT_W;
  localparam int IDX_W   = $clog2(MAX_DEPTH);
  localparam int PW      = (IDX_W + 1 > DEPTH_W) ? IDX_W + 1 : DEPTH_W;
  localparam int SUM_W   = SAMPLE_BITS + CNT_W;

  logic signed [SAMPLE_BITS-1:0] mem [MAX_DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd_data;

  logic [DEPTH_W-1:0] depth;
  logic [DEPTH_W-1:0] eff;
  logic [IDX_W-1:0]   head;
  logic [IDX_W-1:0]   tail;
  logic [CNT_W-1:0]   cnt;

  sfws_pkg::action_t act;
  sfws_pkg::status_t res_status;
  logic signed [SAMPLE_BITS-1:0] smp;

  logic [IDX_W-1:0]   walk_idx;
  logic [CNT_W-1:0]   rem;
  logic               rd_issue;
  logic               first;
  logic signed [SAMPLE_BITS-1:0] lo;
  logic signed [SAMPLE_BITS-1:0] hi;
  logic signed [SAMPLE_BITS-1:0] prev;
  logic signed [SUM_W-1:0]       sum;
  logic                          up;

  logic             rd_en;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] wr_idx;
  logic [SUM_W-1:0] sum_mag;
  logic [SUM_W-1:0] quot;
  logic             div_busy;
  logic signed [SAMPLE_BITS-1:0] q_s;
  logic             is_stat;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx,
                                                input logic [DEPTH_W-1:0] d);
    logic [PW-1:0] nxt;
    nxt = PW'(idx) + PW'(1);
    if (nxt >= PW'(d)) return '0;
    return IDX_W'(nxt);
  endfunction

  // A depth of zero acts as one, and anything above the store size is clamped.
  always_comb begin
    if (depth == '0) begin
      eff = DEPTH_W'(1);
    end else if (32'(depth) > MAX_DEPTH) begin
      eff = DEPTH_W'(MAX_DEPTH);
    end else begin
      eff = depth;
    end
  end

  assign wr_idx = (cnt == '0) ? '0 : wrap_inc(tail, eff);
  assign rd_en  = cmd.deq_read || (cmd.walk && (rem != '0));
  assign rd_idx = cmd.walk ? walk_idx : head;

  always_ff @(posedge clk) begin
    if (cmd.enq_write) begin
      mem[wr_idx] <= smp;
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

  // Queue pointers and fill count; the buffer is empty exactly when the count is zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= DEPTH_W'(sfws_pkg::DEPTH_RESET);
      head  <= '0;
      tail  <= '0;
      cnt   <= '0;
    end else if (cfg_wr_en) begin
      depth <= cfg_wr_data;
      head  <= '0;
      tail  <= '0;
      cnt   <= '0;
    end else if (cmd.enq_write) begin
      if (cnt == '0) begin
        head <= '0;
      end
      tail <= wr_idx;
      cnt  <= cnt + CNT_W'(1);
    end else if (cmd.deq_read) begin
      if (cnt == CNT_W'(1)) begin
        head <= '0;
        tail <= '0;
      end else begin
        head <= wrap_inc(head, eff);
      end
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act        <= in_action;
      smp        <= in_sample;
      res_status <= sfws_pkg::ST_DONE;
    end else if (cmd.status_we) begin
      res_status <= cmd.status_code;
    end
  end

  // Statistics walk: a read is issued each cycle while samples remain, and the
  // registered read data is folded into the statistics.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_issue <= 1'b0;
      rem      <= '0;
    end else begin
      rd_issue <= cmd.walk && (rem != '0);
      if (cmd.stat_init) begin
        rem <= cnt;
      end else if (cmd.walk && (rem != '0)) begin
        rem <= rem - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.stat_init) begin
      walk_idx <= head;
      first    <= 1'b1;
      up       <= 1'b1;
    end else begin
      if (cmd.walk && (rem != '0)) begin
        walk_idx <= wrap_inc(walk_idx, eff);
      end
      if (rd_issue) begin
        first <= 1'b0;
        prev  <= rd_data;
        if (first) begin
          lo  <= rd_data;
          hi  <= rd_data;
          sum <= SUM_W'(rd_data);
        end else begin
          if (rd_data < lo) lo <= rd_data;
          if (rd_data > hi) hi <= rd_data;
          if (rd_data <= prev) up <= 1'b0;
          sum <= sum + SUM_W'(rd_data);
        end
      end
    end
  end

  assign sum_mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

  sfws_div #(
    .N_W (SUM_W),
    .D_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sum_mag),
    .divisor  (cnt),
    .busy     (div_busy),
    .quotient (quot)
  );

  assign q_s     = SAMPLE_BITS'(quot);
  assign is_stat = (act == sfws_pkg::ACT_STAT) && (res_status == sfws_pkg::ST_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status <= res_status;
      out_count  <= (res_status == sfws_pkg::ST_EMPTY) ? '0 : cnt;
      out_data   <= ((act == sfws_pkg::ACT_DEQ) && (res_status == sfws_pkg::ST_DONE))
                    ? rd_data : '0;
      out_min    <= is_stat ? lo : '0;
      out_max    <= is_stat ? hi : '0;
      out_mean   <= is_stat ? (sum[SUM_W-1] ? -q_s : q_s) : '0;
      out_rising <= is_stat && up && (cnt >= CNT_W'(2));
      out_single <= is_stat && (cnt == CNT_W'(1));
    end
  end

  assign st.act       = act;
  assign st.empty     = (cnt == '0);
  assign st.full      = (cnt >= eff);
  assign st.walk_done = (rem == '0) && !rd_issue;
  assign st.div_busy  = div_busy;
  assign st.out_free  = !out_valid || out_ready;

endmodule

// ----- src/sfws_ctrl.sv -----
// Controller state machine: sequences one word through the datapath.
// Depends on sfws_pkg for the command and status structs.
module sfws_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  sfws_pkg::stat_t st,
  output sfws_pkg::cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_WALK = 5'b00100,
    S_DIV  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_FIN;
        case (st.act)
          sfws_pkg::ACT_ENQ: begin
            if (st.full) begin
              cmd.status_we   = 1'b1;
              cmd.status_code = sfws_pkg::ST_FULL;
            end else begin
              cmd.enq_write = 1'b1;
            end
          end
          sfws_pkg::ACT_DEQ: begin
            if (st.empty) begin
              cmd.status_we   = 1'b1;
              cmd.status_code = sfws_pkg::ST_EMPTY;
            end else begin
              cmd.deq_read = 1'b1;
            end
          end
          sfws_pkg::ACT_STAT: begin
            if (st.empty) begin
              cmd.status_we   = 1'b1;
              cmd.status_code = sfws_pkg::ST_EMPTY;
            end else begin
              cmd.stat_init = 1'b1;
              state_next    = S_WALK;
            end
          end
          default: begin
          end
        endcase
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (st.walk_done) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (!st.div_busy) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- src/sample_fifo_with_window_stats_core.sv -----
// Enqueue, dequeue and no-op words pass through the execute and finish states after
// acceptance; a statistics word also walks its n held samples (one memory read per
// sample) and then runs the divider, one quotient bit per cycle.
// Throughput: one word at a time; the next word is taken once the result sits in the
// output register. Synchronous active-high reset empties the queue, sets depth 64.
module sample_fifo_with_window_stats_core #(
  parameter int MAX_DEPTH   = sfws_pkg::MAX_DEPTH_DEF,
  parameter int SAMPLE_BITS = sfws_pkg::SAMPLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [sfws_pkg::DEPTH_W-1:0] cfg_wr_data,
  sfws_in_if.sink                      in_ch,
  sfws_out_if.source                   out_ch
);

  sfws_pkg::cmd_t  cmd;
  sfws_pkg::stat_t st;
  logic            in_ready;

  assign in_ch.ready = in_ready;

  sfws_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  sfws_dp #(
    .MAX_DEPTH   (MAX_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_action   (in_ch.action),
    .in_sample   (in_ch.sample),
    .cmd         (cmd),
    .st          (st),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .out_status  (out_ch.status),
    .out_data    (out_ch.data_out),
    .out_count   (out_ch.count),
    .out_min     (out_ch.minimum),
    .out_max     (out_ch.maximum),
    .out_mean    (out_ch.mean),
    .out_rising  (out_ch.rising),
    .out_single  (out_ch.single)
  );

  // An accepted word keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken again right after an accepted word");

  // A result is never loaded over one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> st.out_free)
    else $error("result register overwritten while still valid");

  // The effective depth is at least one, so an empty queue is never full.
  a_empty_not_full: assert property (@(posedge clk) disable iff (rst)
    st.empty |-> !st.full)
    else $error("queue reported both empty and full");

  // Starting a division always makes the divider busy.
  a_div_runs: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> st.div_busy)
    else $error("divider did not start");

endmodule
